/* design/rau_pkg.sv */
// Package for the rational arithmetic unit: command, status and order codes,
// word-width constants and the controller state type. No dependencies.
`default_nettype none
package rau_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int IN_BITS = 32;
  localparam int MAG_BITS = 64;
  localparam int CNT_BITS = 7;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [1:0] ORD_LESS = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE, S_CHECK, S_G1, S_G1W, S_RED1, S_RED1W, S_RED1D, S_RED1DW, S_G2, S_G2W,
    S_RED2, S_RED2W, S_RED2D, S_RED2DW, S_GD, S_GDW, S_Q1, S_Q1W, S_Q2, S_Q2W,
    S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_COMB, S_GF, S_GFW, S_F1, S_F1W,
    S_F2, S_F2W, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic start_div;
    logic start_mul;
  } unit_ctl_t;
endpackage
`default_nettype wire

/* design/rau_div.sv */
// Bit-serial restoring divider for 64-bit unsigned magnitudes, one
// quotient bit per cycle. Uses rau_pkg.
`default_nettype none
module rau_div
  import rau_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [MAG_BITS-1:0] dividend,
  input  wire logic [MAG_BITS-1:0] divisor,
  output logic                     done,
  output logic [MAG_BITS-1:0]      quot,
  output logic [MAG_BITS-1:0]      rem
);
  logic [MAG_BITS-1:0] dvs;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [MAG_BITS:0]   trial;

  assign trial = {rem, quot[MAG_BITS-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(MAG_BITS);
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial[MAG_BITS]) begin
          rem  <= {rem[MAG_BITS-2:0], quot[MAG_BITS-1]};
          quot <= {quot[MAG_BITS-2:0], 1'b0};
        end else begin
          rem  <= trial[MAG_BITS-1:0];
          quot <= {quot[MAG_BITS-2:0], 1'b1};
        end
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
endmodule
`default_nettype wire

/* design/rau_mul.sv */
// Bit-serial shift-and-add multiplier, 64-bit operands, low 64 bits of
// the product, one multiplier bit per cycle. Uses rau_pkg.
`default_nettype none
module rau_mul
  import rau_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [MAG_BITS-1:0] op_a,
  input  wire logic [MAG_BITS-1:0] op_b,
  output logic                     done,
  output logic [MAG_BITS-1:0]      prod
);
  logic [MAG_BITS-1:0] mcand;
  logic [MAG_BITS-1:0] mplier;
  logic                busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mcand  <= op_a;
        mplier <= op_b;
        prod   <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= {mcand[MAG_BITS-2:0], 1'b0};
        mplier <= {1'b0, mplier[MAG_BITS-1:1]};
        if (mplier[MAG_BITS-1:1] == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("multiplier not busy after start");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done held");
endmodule
`default_nettype wire

/* design/rational_arithmetic_unit_core.sv */
// Top level of the rational arithmetic unit: sequencer with a shared
// bit-serial divider and multiplier. Uses rau_pkg, rau_div and rau_mul.
//
// Input channel s_axis: tdata carries, from bit 0 up, command, a_num,
// a_den, b_num and b_den. Output channel m_axis: tdata carries, from bit
// 0 up, res_num, res_den, order and status. One item in gives one item out.
// The block works on one item at a time. Each step of Euclid's algorithm
// and each division takes one pass of the divider, and each product one
// pass of the multiplier, which stops at the top set bit of its second
// operand. A rejected item goes from S_CHECK straight to S_OUT. The
// divider passes of the gcd chains dominate the run time. s_axis_tready
// is high only while the sequencer is idle. A finished item is held in
// the output register until taken; while m_axis stalls no new item is
// accepted. Reset returns the sequencer to idle, which drops
// m_axis_tvalid; it does not clear the output register.
`default_nettype none
module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // res_num[31:0], res_den[62:32], order[64:63], status[66:65]
  output logic [71:0]       m_axis_tdata
);
  localparam int EB = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
  localparam logic [MAG_BITS-1:0] LIM = MAG_BITS'(1) << (EB - 1);

  state_t state, state_next;
  unit_ctl_t ctl;

  logic [2:0]          cmd;
  logic                san, sbn, sr;
  logic [MAG_BITS-1:0] man, mad, mbn, mbd, gx, gy, ta, tb, num, den, gd;
  logic [MAG_BITS-1:0] div_a, div_b, mul_a, mul_b, quot, rem, prod;
  logic                div_done, mul_done, gcd_end;
  logic [31:0]         res_num;
  logic [30:0]         res_den;
  logic [1:0]          order, status;

  rau_div u_div (
    .clk(clk), .rst(rst), .start(ctl.start_div), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(quot), .rem(rem)
  );
  rau_mul u_mul (
    .clk(clk), .rst(rst), .start(ctl.start_mul), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .prod(prod)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, status, order, res_den, res_num};
  assign gcd_end = (gy == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_CHECK;
      S_CHECK: begin
        if (cmd > CMD_CMP || mad == '0 || mbd == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_G1;
        end
      end
      S_G1:    state_next = gcd_end ? S_RED1 : S_G1W;
      S_G1W:   if (div_done) state_next = S_G1;
      S_RED1:  state_next = S_RED1W;
      S_RED1W: if (div_done) state_next = S_RED1D;
      S_RED1D: state_next = S_RED1DW;
      S_RED1DW: if (div_done) state_next = S_G2;
      S_G2:    state_next = gcd_end ? S_RED2 : S_G2W;
      S_G2W:   if (div_done) state_next = S_G2;
      S_RED2:  state_next = S_RED2W;
      S_RED2W: if (div_done) state_next = S_RED2D;
      S_RED2D: state_next = S_RED2DW;
      S_RED2DW: begin
        if (div_done) begin
          if (cmd == CMD_MUL || cmd == CMD_DIV) begin
            state_next = (cmd == CMD_DIV && mbn == '0) ? S_OUT : S_M1;
          end else begin
            state_next = S_GD;
          end
        end
      end
      S_GD:    state_next = gcd_end ? S_Q1 : S_GDW;
      S_GDW:   if (div_done) state_next = S_GD;
      S_Q1:    state_next = S_Q1W;
      S_Q1W:   if (div_done) state_next = S_Q2;
      S_Q2:    state_next = S_Q2W;
      S_Q2W:   if (div_done) state_next = S_M1;
      S_M1:    state_next = S_M1W;
      S_M1W:   if (mul_done) state_next = S_M2;
      S_M2:    state_next = S_M2W;
      S_M2W:   if (mul_done) state_next = S_M3;
      S_M3:    state_next = S_M3W;
      S_M3W:   if (mul_done) state_next = S_COMB;
      S_COMB:  state_next = (cmd == CMD_CMP) ? S_OUT : S_GF;
      S_GF:    state_next = gcd_end ? S_F1 : S_GFW;
      S_GFW:   if (div_done) state_next = S_GF;
      S_F1:    state_next = S_F1W;
      S_F1W:   if (div_done) state_next = S_F2;
      S_F2:    state_next = S_F2W;
      S_F2W:   if (div_done) state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Divider and multiplier operand selection and start strobes.
  always_comb begin
    ctl   = '0;
    div_a = gx;
    div_b = gy;
    mul_a = man;
    mul_b = mbd;
    unique case (state)
      S_G1, S_G2, S_GD, S_GF: ctl.start_div = !gcd_end;
      S_RED1, S_RED1D, S_RED2, S_RED2D, S_Q1, S_Q2, S_F1, S_F2: ctl.start_div = 1'b1;
      S_M1, S_M2, S_M3: ctl.start_mul = 1'b1;
      default: ;
    endcase
    unique case (state)
      S_RED1:  begin div_a = man; div_b = gx; end
      S_RED1D: begin div_a = mad; div_b = gd; end
      S_RED2:  begin div_a = mbn; div_b = gx; end
      S_RED2D: begin div_a = mbd; div_b = gd; end
      S_Q1:    begin div_a = mbd; div_b = gx; end
      S_Q2:    begin div_a = mad; div_b = gd; end
      S_F1:    begin div_a = num; div_b = gx; end
      S_F2:    begin div_a = den; div_b = gd; end
      default: ;
    endcase
    unique case (state)
      S_M1: begin
        mul_a = man;
        mul_b = (cmd == CMD_MUL) ? mbn : ((cmd == CMD_DIV) ? mbd : ta);
      end
      S_M2: begin
        mul_a = mbn;
        mul_b = (cmd == CMD_MUL) ? mbd : ((cmd == CMD_DIV) ? mbn : tb);
      end
      S_M3: begin
        mul_a = mad;
        mul_b = (cmd == CMD_MUL) ? mbd : ((cmd == CMD_DIV) ? mbn : den);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers. For add, subtract and compare ta and tb first hold
  // the cofactors mbd/gd and mad/gd, then the scaled numerators; den first
  // holds mbd/gd, then the common denominator.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd <= s_axis_tdata[2:0];
        san <= s_axis_tdata[34] ^ s_axis_tdata[66];
        sbn <= s_axis_tdata[98] ^ s_axis_tdata[130];
        man <= MAG_BITS'(s_axis_tdata[34] ? 33'(-{1'b1, s_axis_tdata[34:3]})
                                          : 33'({1'b0, s_axis_tdata[34:3]}));
        mad <= MAG_BITS'(s_axis_tdata[66] ? 33'(-{1'b1, s_axis_tdata[66:35]})
                                          : 33'({1'b0, s_axis_tdata[66:35]}));
        mbn <= MAG_BITS'(s_axis_tdata[98] ? 33'(-{1'b1, s_axis_tdata[98:67]})
                                          : 33'({1'b0, s_axis_tdata[98:67]}));
        mbd <= MAG_BITS'(s_axis_tdata[130] ? 33'(-{1'b1, s_axis_tdata[130:99]})
                                           : 33'({1'b0, s_axis_tdata[130:99]}));
      end
      S_CHECK: begin
        res_num <= '0;
        res_den <= '0;
        order   <= ORD_LESS;
        status  <= ST_ZERO;
        gx      <= man;
        gy      <= mad;
      end
      S_G1W, S_G2W, S_GDW, S_GFW: if (div_done) begin gx <= gy; gy <= rem; end
      S_RED1: gd <= gx;
      S_RED1W: if (div_done) begin
        man <= quot;
        if (quot == '0) san <= 1'b0;
      end
      S_G1: ;
      S_G2: ;
      S_RED2: ;
      S_Q1: gd <= gx;
      S_F1: gd <= gx;
      default: ;
    endcase
    if (state == S_RED1DW && div_done) begin
      mad <= quot;
      gx  <= mbn;
      gy  <= mbd;
    end
    if (state == S_G1 && gcd_end) gd <= gx;
    if (state == S_RED2W && div_done) begin
      mbn <= quot;
      if (quot == '0) sbn <= 1'b0;
      if (cmd == CMD_DIV && quot == '0) begin
        status <= ST_ZERO;
      end
    end
    if (state == S_G2 && gcd_end) gd <= gx;
    if (state == S_RED2DW && div_done) begin
      mbd <= quot;
      gx  <= mad;
      gy  <= quot;
    end
    if (state == S_Q1W && div_done) begin
      ta  <= quot;
      den <= quot;
    end
    if (state == S_Q2W && div_done) tb <= quot;
    if (state == S_M1W && mul_done) ta <= prod;
    if (state == S_M2W && mul_done) tb <= prod;
    if (state == S_M3W && mul_done) den <= prod;
    if (state == S_COMB) begin
      if (cmd == CMD_MUL || cmd == CMD_DIV) begin
        num <= ta;
        sr  <= (san != sbn) && ta != '0;
        gx  <= ta;
        gy  <= den;
      end else begin
        // Signed sum of ta and the possibly negated tb.
        if (san == ((cmd == CMD_ADD) ? sbn : !sbn) || tb == '0) begin
          num <= ta + tb;
          sr  <= (tb == '0) ? san : san;
          gx  <= ta + tb;
        end else if (ta >= tb) begin
          num <= ta - tb;
          sr  <= san;
          gx  <= ta - tb;
        end else begin
          num <= tb - ta;
          sr  <= !san;
          gx  <= tb - ta;
        end
        gy <= den;
        if (cmd == CMD_CMP) begin
          status <= ST_OK;
          if (ta == tb && (san != ((cmd == CMD_ADD) ? sbn : !sbn) || ta == '0)) begin
            order <= ORD_EQUAL;
          end else if (san == !sbn || tb == '0) begin
            order <= san ? ORD_LESS : ORD_GREATER;
          end else begin
            order <= ((ta >= tb) ? san : !san) ? ORD_LESS : ORD_GREATER;
          end
        end
      end
    end
    if (state == S_F1W && div_done) begin
      num <= quot;
      if (quot == '0) sr <= 1'b0;
    end
    if (state == S_F2W && div_done) den <= quot;
    if (state == S_FIN) begin
      if (den > LIM - 1 || (sr ? (num > LIM) : (num > LIM - 1))) begin
        status <= ST_OVF;
      end else begin
        status  <= ST_OK;
        res_num <= sr ? 32'(-num) : num[31:0];
        res_den <= den[30:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");
  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.start_div && ctl.start_mul))
    else $error("divider and multiplier started together");
endmodule
`default_nettype wire
